/* sv/ede_pkg.sv */
// shared types and constants for the edit distance engine
`timescale 1ns / 1ps

package ede_pkg;

   // command codes of an input transaction
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_SECOND = 1'b1;

   // width and ceiling of the reported distance
   localparam int DIST_W = 6;
   localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

   // token handed from one cell to the next
   typedef struct packed {
      logic       valid;     // carries a second-string byte that updates the row
      logic       last;      // marks the end of the second string
      logic [7:0] char_val;  // the second-string byte
   } ede_tok_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic       clear;     // restore the initial row and drop tokens
      logic       write;     // store an appended first-string byte
      logic [7:0] wr_char;   // byte to store
   } ede_ctrl_type;

endpackage

/* sv/ede_if.sv */
// request and response channel interfaces of the edit distance engine
`timescale 1ns / 1ps

interface ede_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] character;
   logic       is_last;

   modport source (output valid, output command, output character, output is_last,
                   input ready);
   modport sink (input valid, input command, input character, input is_last,
                 output ready);
endinterface

interface ede_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] distance;
   logic       overflow;

   modport source (output valid, output distance, output overflow, input ready);
   modport sink (input valid, input distance, input overflow, output ready);
endinterface

/* sv/edit_distance_engine_core.sv */
// top level of the edit distance engine: control, source stage and chain of cells
//
//   port       dir   transaction
//   req_port   in    command, character, is_last
//   rsp_port   out   distance, overflow
//
// appends and second-string bytes are taken one per cycle until a last byte is taken.
// a byte marked last travels the cell chain; the result is found when it reaches the
// cell of the final first-string byte and passes through the hold register.
// there is one cell per first-string byte, which sets how far the last byte goes.
// the request side reopens once the result moves into the response register, so it
// stalls longer only while an earlier response still waits there.
// reset is synchronous and active high; it empties both strings.
`timescale 1ns / 1ps

module edit_distance_engine_core #(
   parameter int MAX_LEN = 32
) (
   input  logic      clock,
   input  logic      reset,
   ede_req_if.sink   req_port,
   ede_rsp_if.source rsp_port
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int SW = LW + ede_pkg::DIST_W;

   logic [LW-1:0]        first_length_ff, first_length_in;
   logic [LW-1:0]        second_length_ff, second_length_in;
   logic                 exceeded_ff, exceeded_in;
   logic                 busy_ff, busy_in;
   logic                 hold_valid_ff, hold_valid_in;
   logic [LW-1:0]        hold_dist_ff, hold_dist_in;
   logic                 hold_ovf_ff, hold_ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [5:0]           rsp_dist_ff, rsp_dist_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   ede_pkg::ede_tok_type src_tok_ff, src_tok_in;
   logic [LW-1:0]        src_new_ff, src_new_in;
   logic [LW-1:0]        src_diag_ff, src_diag_in;

   ede_pkg::ede_ctrl_type ctrl;
   ede_pkg::ede_tok_type  tok [0:MAX_LEN];
   logic [LW-1:0]         new_val [0:MAX_LEN];
   logic [LW-1:0]         diag_val [0:MAX_LEN];
   logic [LW-1:0]         row_val [0:MAX_LEN];
   logic [MAX_LEN:0]      done_vec;

   logic                  accept;
   logic                  hold_move;
   logic                  done_any;
   logic [LW-1:0]         done_dist;
   logic [SW-1:0]         wide_dist;

   assign accept    = req_port.valid && !busy_ff;
   assign hold_move = hold_valid_ff && (!rsp_valid_ff || rsp_port.ready);

   // source stage feeds the chain as row entry zero
   assign tok[0]      = src_tok_ff;
   assign new_val[0]  = src_new_ff;
   assign diag_val[0] = src_diag_ff;
   assign row_val[0]  = second_length_ff;
   assign done_vec[0] = src_tok_ff.last && (first_length_ff == '0);

   // chain of cells, one per first-string position
   for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
      ede_cell #(
         .INDEX (j),
         .LW    (LW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .first_length (first_length_ff),
         .in_tok       (tok[j-1]),
         .in_new       (new_val[j-1]),
         .in_diag      (diag_val[j-1]),
         .out_tok      (tok[j]),
         .out_new      (new_val[j]),
         .out_diag     (diag_val[j]),
         .row_val      (row_val[j]),
         .done         (done_vec[j])
      );
   end

   // pick the row entry of the final cell when the last token reaches it
   always_comb begin
      done_any  = 1'b0;
      done_dist = '0;
      for (int k = 0; k <= MAX_LEN; k++) begin
         done_any  = done_any | done_vec[k];
         done_dist = done_dist | (done_vec[k] ? row_val[k] : '0);
      end
   end

   // broadcast control to the cells
   always_comb begin
      ctrl.clear   = done_any;
      ctrl.write   = accept && (req_port.command == ede_pkg::CMD_APPEND) &&
                     (second_length_ff == '0) && (first_length_ff < LW'(MAX_LEN));
      ctrl.wr_char = req_port.character;
   end

   // request decode and string bookkeeping
   always_comb begin
      first_length_in  = first_length_ff;
      second_length_in = second_length_ff;
      exceeded_in      = exceeded_ff;
      busy_in          = busy_ff;
      src_tok_in       = '0;
      src_new_in       = second_length_ff + LW'(1);
      src_diag_in      = second_length_ff;

      if (accept) begin
         if (req_port.command == ede_pkg::CMD_APPEND) begin
            if (second_length_ff == '0) begin
               if (first_length_ff < LW'(MAX_LEN)) begin
                  first_length_in = first_length_ff + LW'(1);
               end else begin
                  exceeded_in = 1'b1;
               end
            end
         end else begin
            src_tok_in.last     = req_port.is_last;
            src_tok_in.char_val = req_port.character;
            if (second_length_ff < LW'(MAX_LEN)) begin
               src_tok_in.valid = 1'b1;
               second_length_in = second_length_ff + LW'(1);
            end else begin
               exceeded_in = 1'b1;
            end
            if (req_port.is_last) begin
               busy_in = 1'b1;
            end
         end
      end

      // result found: empty both strings
      if (done_any) begin
         first_length_in  = '0;
         second_length_in = '0;
         exceeded_in      = 1'b0;
      end

      if (hold_move) begin
         busy_in = 1'b0;
      end
   end

   // result hold and response register
   always_comb begin
      wide_dist     = SW'(done_dist);
      hold_valid_in = hold_valid_ff;
      hold_dist_in  = hold_dist_ff;
      hold_ovf_in   = hold_ovf_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (hold_move) begin
         hold_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         wide_dist     = SW'(hold_dist_ff);
         rsp_dist_in   = (wide_dist > SW'(ede_pkg::DIST_MAX)) ? ede_pkg::DIST_MAX :
                         wide_dist[5:0];
         rsp_ovf_in    = hold_ovf_ff;
      end
      if (done_any) begin
         hold_valid_in = 1'b1;
         hold_dist_in  = done_dist;
         hold_ovf_in   = exceeded_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_length_ff  <= '0;
         second_length_ff <= '0;
         exceeded_ff      <= 1'b0;
         busy_ff          <= 1'b0;
         hold_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         src_tok_ff       <= '0;
      end else begin
         first_length_ff  <= first_length_in;
         second_length_ff <= second_length_in;
         exceeded_ff      <= exceeded_in;
         busy_ff          <= busy_in;
         hold_valid_ff    <= hold_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         src_tok_ff       <= src_tok_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_dist_ff <= hold_dist_in;
      hold_ovf_ff  <= hold_ovf_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      src_new_ff   <= src_new_in;
      src_diag_ff  <= src_diag_in;
   end

   assign req_port.ready    = !busy_ff;
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.distance = rsp_dist_ff;
   assign rsp_port.overflow = rsp_ovf_ff;

   // only the final cell can report the end of a second string
   assert property (@(posedge clock) disable iff (reset) $onehot0(done_vec))
      else $error("more than one cell reported a result");

   // a result only appears while a last byte is outstanding
   assert property (@(posedge clock) disable iff (reset) done_any |-> busy_ff)
      else $error("result found with no last byte outstanding");

   // the held result keeps the request side closed
   assert property (@(posedge clock) disable iff (reset) hold_valid_ff |-> busy_ff)
      else $error("held result without busy");

   // both strings are empty after a result
   assert property (@(posedge clock) disable iff (reset)
      done_any |=> (first_length_ff == '0) && (second_length_ff == '0))
      else $error("strings not cleared after result");

endmodule

/* sv/ede_cell.sv */
// one cell of the systolic row: holds one first-string byte and one row entry
`timescale 1ns / 1ps

module ede_cell #(
   parameter int INDEX = 1,
   parameter int LW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ede_pkg::ede_ctrl_type ctrl,
   input  logic [LW-1:0]        first_length,
   input  ede_pkg::ede_tok_type in_tok,
   input  logic [LW-1:0]        in_new,
   input  logic [LW-1:0]        in_diag,
   output ede_pkg::ede_tok_type out_tok,
   output logic [LW-1:0]        out_new,
   output logic [LW-1:0]        out_diag,
   output logic [LW-1:0]        row_val,
   output logic                 done
);

   logic [7:0]           char_ff;
   logic [LW-1:0]        row_ff;
   ede_pkg::ede_tok_type tok_ff;
   logic [LW-1:0]        new_ff;
   logic [LW-1:0]        diag_ff;

   logic                 cost;
   logic [LW:0]          above_p1;
   logic [LW:0]          left_p1;
   logic [LW:0]          diag_pc;
   logic [LW:0]          least;
   logic [LW-1:0]        row_in;

   // unit-cost recurrence: min of delete, insert and substitute
   always_comb begin
      cost     = (char_ff != in_tok.char_val);
      above_p1 = {1'b0, row_ff} + (LW+1)'(1);
      left_p1  = {1'b0, in_new} + (LW+1)'(1);
      diag_pc  = {1'b0, in_diag} + (LW+1)'(cost);
      least    = above_p1;
      if (left_p1 < least) begin
         least = left_p1;
      end
      if (diag_pc < least) begin
         least = diag_pc;
      end
      row_in = least[LW-1:0];
   end

   // row entry and token hand-off
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         row_ff <= LW'(INDEX);
         tok_ff <= '0;
      end else begin
         if (in_tok.valid) begin
            row_ff <= row_in;
         end
         tok_ff <= in_tok;
      end
   end

   // token payload, passed along with the flags
   always_ff @(posedge clock) begin
      new_ff  <= row_in;
      diag_ff <= row_ff;
   end

   // first-string byte, written when this cell is the next free position
   always_ff @(posedge clock) begin
      if (ctrl.write && (first_length == LW'(INDEX - 1))) begin
         char_ff <= ctrl.wr_char;
      end
   end

   assign out_tok  = tok_ff;
   assign out_new  = new_ff;
   assign out_diag = diag_ff;
   assign row_val  = row_ff;
   assign done     = tok_ff.last && (first_length == LW'(INDEX));

endmodule
